// File: src/at_response_line_framer_macros.svh
// Assertion macros shared by the framer RTL; they compile to nothing for synthesis.
`ifndef AT_RESPONSE_LINE_FRAMER_MACROS_SVH
`define AT_RESPONSE_LINE_FRAMER_MACROS_SVH

`ifndef SYNTHESIS

// Checks that a condition holds at every clock edge outside reset.
`define ARLF_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("framer check failed: condition");

// Checks that a trigger implies a consequence in the same cycle.
`define ARLF_ASSERT_IMPLIES(label, trig, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
    else $error("framer check failed: same-cycle implication");

// Checks that a trigger implies a consequence in the next cycle.
`define ARLF_ASSERT_NEXT(label, trig, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error("framer check failed: next-cycle implication");

`else

`define ARLF_ASSERT_ALWAYS(label, cond)
`define ARLF_ASSERT_IMPLIES(label, trig, cons)
`define ARLF_ASSERT_NEXT(label, trig, cons)

`endif

`endif

// File: src/arlf_pkg.sv
// Shared constants, types and helper functions of the modem response line framer.
`timescale 1ns / 1ps

package arlf_pkg;

  // Line store geometry.
  localparam int LINE_DEPTH = 64;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);
  localparam int FILL_W     = $clog2(LINE_DEPTH + 1);

  // Length of the "+RECV:" header.
  localparam logic [FILL_W-1:0] HDR_LEN = FILL_W'(6);

  // Characters of interest.
  localparam logic [7:0] CH_PROMPT = 8'h3E;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // Result kinds.
  localparam logic KIND_PROMPT = 1'b0;
  localparam logic KIND_MSG    = 1'b1;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROMPT,
    ST_EMIT
  } ctrl_state_t;

  // Phases of the running count parser.
  typedef enum logic [1:0] {
    PH_BLANK,
    PH_DIGIT,
    PH_DONE
  } parse_phase_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;
    logic load_prompt;
    logic load_msg;
    logic k_clear;
    logic fill_clear;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic prompt;
    logic emit;
    logic out_free;
    logic k_last;
  } dp_status_t;

  // Returns the header character expected at a given position.
  function automatic logic [7:0] hdr_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h2B;
      3'd1:    c = 8'h52;
      3'd2:    c = 8'h45;
      3'd3:    c = 8'h43;
      3'd4:    c = 8'h56;
      3'd5:    c = 8'h3A;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Returns whether a byte counts as white space for the count parser.
  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

// File: src/arlf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module arlf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/arlf_datapath.sv
// Datapath: line store, fill and payload counters, header match, count parser, output register.
`timescale 1ns / 1ps

module arlf_datapath import arlf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  dp_cmd_t    cmd,
  output dp_status_t st,
  input  logic [7:0] rx_byte,
  input  logic       out_stall,
  output logic       out_valid,
  output logic       kind,
  output logic [7:0] data_byte,
  output logic       is_last
);

  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_inc;
  logic [7:0]        payload_left;
  logic [7:0]        prev;
  logic              hdr_ok;
  logic              hdr_ok_next;
  parse_phase_t      phase;
  parse_phase_t      phase_next;
  logic [7:0]        val;
  logic [7:0]        val_next;
  logic              neg;
  logic              neg_next;
  logic [ADDR_W-1:0] k;
  logic [ADDR_W-1:0] k_next;
  logic [7:0]        rd_data;
  logic              byp;
  logic [7:0]        byp_data;
  logic [7:0]        count;
  logic [7:0]        val_x10;
  logic [3:0]        digit;
  logic              is_digit;
  logic              full;
  logic              is_prompt;
  logic              store;
  logic              crlf;
  logic              is_hdr;
  logic              in_payload;
  logic              emit_now;
  logic              drop_line;

  // Classification of the byte on the input.
  assign fill_inc   = fill + FILL_W'(1);
  assign full       = (fill >= FILL_W'(LINE_DEPTH));
  assign is_prompt  = (rx_byte == CH_PROMPT);
  assign store      = cmd.take && !full && !is_prompt;
  assign in_payload = (payload_left != 8'd0);
  assign crlf       = (fill_inc >= FILL_W'(2)) && (prev == CH_CR) && (rx_byte == CH_LF);
  assign is_hdr     = crlf && (fill_inc > HDR_LEN) && hdr_ok;
  assign count      = neg ? 8'(8'd0 - val) : val;
  assign emit_now   = in_payload ? (payload_left == 8'd1)
                                 : (crlf && !is_hdr && (fill_inc > FILL_W'(2)));
  assign drop_line  = !in_payload && crlf && !is_hdr && (fill_inc <= FILL_W'(2));

  // Header match over the first six stored bytes.
  always_comb begin
    if (fill == '0) begin
      hdr_ok_next = (rx_byte == hdr_char(3'd0));
    end else if (fill < HDR_LEN) begin
      hdr_ok_next = hdr_ok && (rx_byte == hdr_char(fill[2:0]));
    end else begin
      hdr_ok_next = hdr_ok;
    end
  end

  // One step of the running decimal count parser.
  assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign digit    = 4'(rx_byte - CH_ZERO);
  assign val_x10  = 8'((val << 3) + (val << 1));

  always_comb begin
    phase_next = phase;
    val_next   = val;
    neg_next   = neg;
    if (fill < HDR_LEN) begin
      phase_next = PH_BLANK;
      val_next   = 8'd0;
      neg_next   = 1'b0;
    end else begin
      unique case (phase)
        PH_BLANK: begin
          if (is_blank(rx_byte)) begin
            phase_next = PH_BLANK;
          end else if (rx_byte == CH_PLUS || rx_byte == CH_MINUS) begin
            phase_next = PH_DIGIT;
            neg_next   = (rx_byte == CH_MINUS);
          end else if (is_digit) begin
            phase_next = PH_DIGIT;
            val_next   = {4'd0, digit};
          end else begin
            phase_next = PH_DONE;
          end
        end
        PH_DIGIT: begin
          if (is_digit) begin
            val_next = 8'(val_x10 + {4'd0, digit});
          end else begin
            phase_next = PH_DONE;
          end
        end
        PH_DONE: begin
          phase_next = PH_DONE;
        end
        default: begin
          phase_next = PH_DONE;
        end
      endcase
    end
  end

  // Line store fill, payload count and per-line tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill         <= '0;
      payload_left <= 8'd0;
      hdr_ok       <= 1'b0;
      phase        <= PH_BLANK;
      val          <= 8'd0;
      neg          <= 1'b0;
    end else begin
      if (cmd.fill_clear) begin
        fill <= '0;
      end else if (cmd.take && full) begin
        fill <= '0;
      end else if (store) begin
        fill   <= drop_line ? '0 : fill_inc;
        hdr_ok <= hdr_ok_next;
        phase  <= phase_next;
        val    <= val_next;
        neg    <= neg_next;
        if (in_payload) begin
          payload_left <= payload_left - 8'd1;
        end else if (is_hdr) begin
          payload_left <= count;
        end
      end
    end
  end

  // Last stored byte, for the CR LF check.
  always_ff @(posedge clk) begin
    if (store) begin
      prev <= rx_byte;
    end
  end

  // Read pointer for emission; the RAM reads at the next pointer value.
  always_comb begin
    if (cmd.k_clear || (cmd.load_msg && st.k_last)) begin
      k_next = '0;
    end else if (cmd.load_msg) begin
      k_next = k + ADDR_W'(1);
    end else begin
      k_next = k;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else begin
      k <= k_next;
    end
  end

  arlf_ram #(
    .WIDTH (8),
    .DEPTH (LINE_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (store),
    .waddr (fill[ADDR_W-1:0]),
    .wdata (rx_byte),
    .raddr (k_next),
    .rdata (rd_data)
  );

  // A byte written at the address being read in the same cycle is passed around the RAM.
  always_ff @(posedge clk) begin
    if (rst) begin
      byp <= 1'b0;
    end else begin
      byp <= store && (fill[ADDR_W-1:0] == k_next);
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      byp_data <= rx_byte;
    end
  end

  // Output register: holds a result beat until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_prompt || cmd.load_msg) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_prompt) begin
      kind      <= KIND_PROMPT;
      data_byte <= 8'd0;
      is_last   <= 1'b1;
    end else if (cmd.load_msg) begin
      kind      <= KIND_MSG;
      data_byte <= byp ? byp_data : rd_data;
      is_last   <= st.k_last;
    end
  end

  // Status toward the controller.
  always_comb begin
    st.prompt   = !full && is_prompt;
    st.emit     = !full && !is_prompt && emit_now;
    st.out_free = !out_valid || !out_stall;
    st.k_last   = (FILL_W'(k) == (fill - FILL_W'(1)));
  end

endmodule

// File: src/arlf_ctrl.sv
// Controller state machine: byte intake, prompt result and message emission sequencing.
`timescale 1ns / 1ps

module arlf_ctrl import arlf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t st,
  output dp_cmd_t    cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.k_clear = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          if (st.prompt) begin
            state_next = ST_PROMPT;
          end else if (st.emit) begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_PROMPT: begin
        if (st.out_free) begin
          cmd.load_prompt = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (st.out_free) begin
          cmd.load_msg = 1'b1;
          if (st.k_last) begin
            cmd.fill_clear = 1'b1;
            state_next     = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: src/at_response_line_framer.sv
// Top level of the modem response line framer.
`timescale 1ns / 1ps
`include "at_response_line_framer_macros.svh"

// Frames modem serial bytes into results. Input beats are taken only while idle.
// A '>' gives a prompt beat once the output register is free.
// A byte that completes a line, or the last byte of a "+RECV:" payload, starts
// emission of the whole line store: n stored bytes leave as n message beats, one
// per cycle at most, read through the single read port of the 64-entry line store,
// and input is held off until the last beat is loaded. A full store drops the next
// byte and starts a new line. No clearing pass is needed after reset.
module at_response_line_framer import arlf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       kind,
  output logic [7:0] data_byte,
  output logic       is_last
);

  dp_cmd_t    cmd;
  dp_status_t st;

  arlf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  arlf_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .rx_byte   (rx_byte),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .kind      (kind),
    .data_byte (data_byte),
    .is_last   (is_last)
  );

  // The output register is loaded only when it is free, and never while a byte is taken.
  `ARLF_ASSERT_IMPLIES(a_load_when_free, cmd.load_msg || cmd.load_prompt, st.out_free && !cmd.take)
  `ARLF_ASSERT_ALWAYS(a_single_load, !(cmd.load_msg && cmd.load_prompt))
  // A prompt beat always carries zero data and the last mark.
  `ARLF_ASSERT_IMPLIES(a_prompt_shape, out_valid && kind == KIND_PROMPT, is_last && data_byte == 8'd0)
  // A taken prompt byte holds off input until its beat is loaded.
  `ARLF_ASSERT_NEXT(a_prompt_holds, cmd.take && st.prompt, in_stall)

endmodule

// File: sim/tb.sv
// Self-checking testbench for the modem response line framer.
`timescale 1ns / 1ps

module tb;
  import arlf_pkg::*;

  // One output beat as the framer presents it.
  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       last;
  } beat_t;

  localparam logic [47:0] RECV_TAG    = "+RECV:";
  localparam int          PHASE_ITEMS = 80;
  localparam int          DRAIN_CYCLES = 200;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic [7:0] rx_byte   = 8'h00;
  logic       out_stall = 1'b0;
  wire        in_stall;
  wire        out_valid;
  wire        kind;
  wire  [7:0] data_byte;
  wire        is_last;

  // Bytes waiting to be sent and message beats still owed by the framer.
  logic [7:0] pend_q[$];
  beat_t      due_beats[$];
  beat_t      head_beat;
  int         mismatches    = 0;
  int         send_idle_pct = 0;
  int         stall_pct     = 0;

  // Shadow copy of the framer state.
  logic [7:0]  line_mem[LINE_DEPTH];
  int unsigned fill_cnt = 0;
  logic [7:0]  pay_left = 8'h00;

  at_response_line_framer u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .data_byte (data_byte),
    .is_last   (is_last)
  );

  always #2 clk = ~clk;

  // Queues the whole stored line as message beats and empties the store.
  task automatic flush_line();
    int unsigned k;
    for (k = 0; k < fill_cnt; k++) begin
      due_beats.push_back(beat_t'{KIND_MSG, line_mem[k], (k == fill_cnt - 1)});
    end
    fill_cnt = 0;
  endtask

  // Advances the shadow state by one received byte and queues its beats.
  task automatic frame_byte(input logic [7:0] c);
    int unsigned k;
    int unsigned i;
    logic        tag_ok;
    logic        neg;
    logic [7:0]  v;
    if (fill_cnt >= LINE_DEPTH) begin
      // A full store swallows this byte and starts over.
      fill_cnt = 0;
    end else if (c == CH_PROMPT) begin
      due_beats.push_back(beat_t'{KIND_PROMPT, 8'h00, 1'b1});
    end else begin
      line_mem[fill_cnt] = c;
      fill_cnt++;
      if (pay_left != 8'h00) begin
        pay_left = pay_left - 8'd1;
        if (pay_left == 8'h00) flush_line();
      end else if (fill_cnt >= 2 && line_mem[fill_cnt - 2] == CH_CR &&
                   line_mem[fill_cnt - 1] == CH_LF) begin
        tag_ok = 1'b1;
        for (k = 0; k < HDR_LEN; k++) begin
          if (line_mem[k] != RECV_TAG[8 * (5 - k) +: 8]) tag_ok = 1'b0;
        end
        if (fill_cnt > HDR_LEN && tag_ok) begin
          // Decode the count: blanks, optional sign, digits, all mod 256.
          i   = HDR_LEN;
          v   = 8'h00;
          neg = 1'b0;
          while (i < fill_cnt && (line_mem[i] == CH_SPACE ||
                 (line_mem[i] >= CH_TAB && line_mem[i] <= CH_CR))) i++;
          if (i < fill_cnt && (line_mem[i] == CH_PLUS || line_mem[i] == CH_MINUS)) begin
            neg = (line_mem[i] == CH_MINUS);
            i++;
          end
          while (i < fill_cnt && line_mem[i] >= CH_ZERO && line_mem[i] <= CH_NINE) begin
            v = v * 8'd10 + (line_mem[i] - CH_ZERO);
            i++;
          end
          pay_left = neg ? 8'h00 - v : v;
        end else if (fill_cnt > 2) begin
          flush_line();
        end else begin
          fill_cnt = 0;
        end
      end
    end
  endtask

  task automatic push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) pend_q.push_back(s[i]);
  endtask

  // Appends one random sequence: mostly well-formed lines and packets.
  task automatic add_random_seq();
    int    pick;
    int    len;
    int    n;
    int    n_eff;
    int    sign;
    int    k;
    string digits;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      // Packet header with a loosely formatted count, then its payload.
      push_text("+RECV:");
      len = $urandom_range(0, 2);
      for (k = 0; k < len; k++) begin
        pend_q.push_back(($urandom_range(0, 5) == 0) ? CH_SPACE :
                         8'($urandom_range(CH_TAB, CH_CR)));
      end
      sign = $urandom_range(0, 3);
      if (sign == 1) pend_q.push_back(CH_PLUS);
      if (sign == 2) pend_q.push_back(CH_MINUS);
      if ($urandom_range(0, 6) == 0) n = 0;
      else if ($urandom_range(0, 4) == 0) n = $urandom_range(0, 999);
      else n = $urandom_range(1, 40);
      digits = $sformatf("%0d", n);
      push_text(digits);
      if ($urandom_range(0, 4) == 0) pend_q.push_back(8'($urandom_range(8'h41, 8'h5A)));
      push_text("\r\n");
      n_eff = n % 256;
      if (sign == 2) n_eff = (256 - n_eff) % 256;
      if (n_eff > 70) n_eff = 70;
      for (k = 0; k < n_eff; k++) pend_q.push_back(8'($urandom_range(0, 255)));
    end else if (pick < 75) begin
      // Plain text line; an empty one is the bare line ending.
      len = $urandom_range(0, 20);
      for (k = 0; k < len; k++) pend_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
      push_text("\r\n");
    end else if (pick < 85) begin
      len = $urandom_range(1, 8);
      for (k = 0; k < len; k++) begin
        case ($urandom_range(0, 3))
          0:       pend_q.push_back(CH_CR);
          1:       pend_q.push_back(CH_LF);
          2:       pend_q.push_back(CH_PROMPT);
          default: pend_q.push_back(8'($urandom_range(0, 255)));
        endcase
      end
    end else if (pick < 91) begin
      pend_q.push_back(CH_PROMPT);
    end else begin
      // Fill the store without a line ending, then one byte more.
      for (k = 0; k < LINE_DEPTH; k++) pend_q.push_back(8'($urandom_range(8'h40, 8'hFF)));
      pend_q.push_back(($urandom_range(0, 1) == 0) ? CH_PROMPT : 8'($urandom_range(0, 255)));
    end
  endtask

  // Input driver: offers the next byte once the previous beat has been taken.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) frame_byte(rx_byte);
      if (!in_valid || !in_stall) begin
        if (pend_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          rx_byte  <= pend_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: checks every accepted beat against the oldest one owed.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_beats.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected beat, expected none, got kind=%0d data=%02h last=%0d",
                   $time, kind, data_byte, is_last);
        end else begin
          head_beat = due_beats.pop_front();
          if (kind !== head_beat.kind || data_byte !== head_beat.data ||
              is_last !== head_beat.last) begin
            mismatches++;
            $display("%0t: expected kind=%0d data=%02h last=%0d, got kind=%0d data=%02h last=%0d",
                     $time, head_beat.kind, head_beat.data, head_beat.last,
                     kind, data_byte, is_last);
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Stimulus: a directed opening, then random traffic under four idle and stall patterns.
  initial begin
    int idle_tbl[4];
    int stall_tbl[4];
    int ph;
    int start;
    idle_tbl  = '{0, 63, 0, 11};
    stall_tbl = '{0, 0, 63, 11};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Prompt, bare line ending, extreme byte values, a short non-header line,
    // and a packet whose payload holds a prompt.
    pend_q.push_back(CH_PROMPT);
    push_text("\r\n");
    pend_q.push_back(8'h00);
    pend_q.push_back(8'hFF);
    push_text("\r\n");
    push_text("+RE\r\n");
    push_text("+RECV:2\r\n");
    push_text("a>b");

    for (ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_tbl[ph];
      stall_pct     = stall_tbl[ph];
      start         = pend_q.size();
      while (pend_q.size() - start < PHASE_ITEMS) add_random_seq();
      while (pend_q.size() != 0 || in_valid || due_beats.size() != 0) @(posedge clk);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && due_beats.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog for a hung run.
  initial begin
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
